[design/cdq_pkg.sv]
// Package for the circular deque: depth, derived widths, operation and status codes.
package cdq_pkg;

    localparam int DEPTH = 128;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int COUNT_OUT_W = 8;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
    endfunction

endpackage

[design/circular_deque.sv]
// Top level of the circular deque: pointer control, word store and result register.
//
// The circular deque holds up to DEPTH signed 32-bit words in a single-port-style
// synchronous store and takes one operation per request beat: push front or rear,
// pop front or rear, or peek front or rear. Every request beat yields exactly one
// response beat carrying the popped or peeked word (zero otherwise), a status
// (ok, overflow on a push into a full deque, underflow on a pop or peek of an
// empty one) and the word count, empty and full flags after the operation.
// Unused opcodes leave the deque untouched and answer ok. Throughput is one
// operation per cycle unless rsp_ready holds the response: head, tail and
// fill count live in registers and are updated at the accepting edge, and the
// store access (one write or one read) is issued at that same edge, so the
// response appears in the cycle after acceptance, from the registered read.
// Because every pointer moves at acceptance, a word pushed in one cycle can
// be popped in the next without any forwarding. The store needs no clearing
// after reset; only entries holding live words are ever read. The response
// register holds while rsp_ready is low, and req_ready follows it, so a new
// request is taken in the same cycle the waiting response leaves.
module circular_deque
    import cdq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [2:0]                    opcode,
    input  logic signed [WORD_W-1:0]      value,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic signed [WORD_W-1:0]      data,
    output logic [1:0]                    status,
    output logic [COUNT_OUT_W-1:0]        count,
    output logic                          is_empty,
    output logic                          is_full
);

    // Pointer and fill state.
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    // Response register; the read word lands in rd_data_reg alongside it.
    logic             rsp_valid_reg;
    logic             rsp_read_reg, rsp_read_next;
    status_t          rsp_status_reg, rsp_status_next;
    logic [CNT_W-1:0] rsp_count_reg;
    logic [WORD_W-1:0] rd_data_reg;

    // Store access for the accepted beat.
    logic [WORD_W-1:0] store_mem [DEPTH];
    logic              wr_en, rd_en;
    logic [IDX_W-1:0]  wr_addr, rd_addr;

    logic accept;
    logic is_full_now, is_empty_now;
    logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

    assign req_ready    = !rsp_valid_reg || rsp_ready;
    assign accept       = req_valid && req_ready;
    assign is_full_now  = (fill_reg == CNT_W'(DEPTH));
    assign is_empty_now = (fill_reg == '0);

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        rsp_status_next = ST_OK;
        rsp_read_next   = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        wr_addr         = head_reg;
        rd_addr         = head_reg;
        unique case (opcode)
            OP_PUSH_FRONT, OP_PUSH_REAR:
            begin
                if (is_full_now)
                begin
                    rsp_status_next = ST_OVERFLOW;
                end
                else
                begin
                    wr_en     = accept;
                    fill_next = fill_reg + CNT_W'(1);
                    if (is_empty_now)
                    begin
                        // A push into an empty deque restarts both ends at entry zero.
                        head_next = '0;
                        tail_next = '0;
                        wr_addr   = '0;
                    end
                    else if (opcode == OP_PUSH_FRONT)
                    begin
                        head_next = idx_prev(head_reg);
                        wr_addr   = idx_prev(head_reg);
                    end
                    else
                    begin
                        tail_next = idx_next(tail_reg);
                        wr_addr   = idx_next(tail_reg);
                    end
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR:
            begin
                if (is_empty_now)
                begin
                    rsp_status_next = ST_UNDERFLOW;
                end
                else
                begin
                    rd_en         = accept;
                    rsp_read_next = 1'b1;
                    rd_addr = (opcode == OP_POP_FRONT || opcode == OP_PEEK_FRONT)
                              ? head_reg : tail_reg;
                    if (opcode == OP_POP_FRONT || opcode == OP_POP_REAR)
                    begin
                        fill_next = fill_reg - CNT_W'(1);
                        // Popping the last word leaves the pointers for the next push to reset.
                        if (fill_reg != CNT_W'(1))
                        begin
                            if (opcode == OP_POP_FRONT)
                                head_next = idx_next(head_reg);
                            else
                                tail_next = idx_prev(tail_reg);
                        end
                    end
                end
            end
            default:
            begin
                // Unused opcodes change nothing and answer ok.
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                fill_reg <= fill_next;
            end
            if (req_ready)
                rsp_valid_reg <= req_valid;
        end
    end

    // Response payload needs no reset; it is qualified by rsp_valid_reg.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rsp_read_reg   <= rsp_read_next;
            rsp_status_reg <= rsp_status_next;
            rsp_count_reg  <= fill_next;
        end
    end

    // Word store: one write or one read per accepted beat, read data registered.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store_mem[wr_addr] <= value;
        if (rd_en)
            rd_data_reg <= store_mem[rd_addr];
    end

    assign count_ext = {{COUNT_OUT_W{1'b0}}, rsp_count_reg};

    assign rsp_valid = rsp_valid_reg;
    assign data      = rsp_read_reg ? rd_data_reg : '0;
    assign status    = rsp_status_reg;
    assign count     = count_ext[COUNT_OUT_W-1:0];
    assign is_empty  = (rsp_count_reg == '0);
    assign is_full   = (rsp_count_reg == CNT_W'(DEPTH));

    // An overflow response must report a full deque.
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_OVERFLOW) |-> is_full)
        else $error("overflow reported without a full deque");

    // An underflow response must report an empty deque.
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == ST_UNDERFLOW) |-> is_empty)
        else $error("underflow reported without an empty deque");

    // An accepted push that is not refused grows the fill count by one.
    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_PUSH_FRONT || opcode == OP_PUSH_REAR) && !is_full_now)
        |=> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("push did not advance the fill count");

    // The fill count never exceeds the depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

endmodule
